>>> rtl/chkvt_pkg.sv
// Package: sizes, codes and control/status bundles of the chained hash table.
`timescale 1ns / 1ps

package chkvt_pkg;

    // Table geometry (both counts are powers of two)
    localparam int BUCKETS = 1024;
    localparam int ENTRIES = 1024;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int LINK_W  = SLOT_W + 1;
    localparam int CLR_N   = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
    localparam int CLR_W   = $clog2(CLR_N);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [BKT_W-1:0]  t_bkt;

    // Empty link marks the end of a chain
    localparam t_link NIL_LINK = LINK_W'(ENTRIES);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_POOL_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RES_NOT_FOUND,
        RES_POOL_FULL,
        RES_FOUND
    } t_res_sel;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INS,
        S_HEAD,
        S_CMP,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     clr_step;
        logic     accept;
        logic     ins_commit;
        logic     head;
        logic     step;
        logic     set_res;
        t_res_sel res_sel;
        logic     load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_cmd cmd;
        logic clr_done;
        logic pool_empty;
        logic head_nil;
        logic hit;
        logic next_nil;
        logic out_free;
    } t_dp_stat;

    function automatic logic link_valid(input t_link l);
        return l < NIL_LINK;
    endfunction

endpackage

>>> rtl/chkvt_req_if.sv
// Interface: request channel (command, key, value) with valid/ready.
`timescale 1ns / 1ps

interface chkvt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] lookup_key;
    logic signed [31:0] entry_value;

    modport source (output valid, output cmd, output lookup_key, output entry_value,
                    input ready);
    modport sink   (input valid, input cmd, input lookup_key, input entry_value,
                    output ready);
endinterface

>>> rtl/chkvt_rsp_if.sv
// Interface: response channel (value, status) with valid/ready.
`timescale 1ns / 1ps

interface chkvt_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

>>> rtl/chkvt_ctrl.sv
// Controller: state machine that sequences clear, insert, chain walk and response.
`timescale 1ns / 1ps

module chkvt_ctrl import chkvt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  t_cmd     i_req_cmd,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Decide next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_req_cmd)
                        CMD_INSERT: n_state = S_INS;
                        CMD_REMOVE: n_state = S_HEAD;
                        CMD_FIND:   n_state = S_HEAD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_INS: begin
                if (i_stat.pool_empty) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_POOL_FULL;
                end else begin
                    o_cmd.ins_commit = 1'b1;
                end
                n_state = S_DONE;
            end
            S_HEAD: begin
                o_cmd.head = 1'b1;
                if (i_stat.head_nil) begin
                    if (i_stat.cmd == CMD_FIND) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_sel = RES_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.cmd == CMD_FIND) begin
                    if (i_stat.hit) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_sel = RES_FOUND;
                        n_state       = S_DONE;
                    end else if (i_stat.next_nil) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_sel = RES_NOT_FOUND;
                        n_state       = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    // Remove visits every entry of the chain
                    o_cmd.step = 1'b1;
                    if (i_stat.next_nil) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/chkvt_dpath.sv
// Datapath: bucket heads, slot store, free stack, chain walk registers, response register.
`timescale 1ns / 1ps

module chkvt_dpath import chkvt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VAL_W-1:0]   i_val,
    input  t_dp_cmd            i_ctl,
    output t_dp_stat           o_stat,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output logic [VAL_W-1:0]   o_rsp_value,
    output logic [1:0]         o_rsp_status
);

    // Storage
    t_link            m_head [BUCKETS];
    logic [KEY_W-1:0] m_key  [ENTRIES];
    logic [VAL_W-1:0] m_val  [ENTRIES];
    t_link            m_next [ENTRIES];
    t_slot            m_free [ENTRIES];

    // Request and walk registers
    t_cmd             r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    t_bkt             r_bkt;
    t_link            r_free_cnt;
    logic [CLR_W-1:0] r_clr_cnt;
    t_link            r_cur;
    t_link            r_prev;
    t_link            r_head_rd;
    t_slot            r_free_rd;
    logic [KEY_W-1:0] r_key_rd;
    logic [VAL_W-1:0] r_val_rd;
    t_link            r_next_rd;
    logic [VAL_W-1:0] r_res;
    t_status          r_stat;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    t_status          r_out_status;

    logic [KEY_W-1:0] w_neg_key;
    t_bkt             w_bkt_in;
    t_link            w_pop;
    logic             w_hit;
    logic             w_rm_hit;
    logic             w_push_ok;
    logic             w_clr_bkt;
    logic             w_clr_slot;
    logic             w_head_we;
    t_bkt             w_head_wa;
    t_link            w_head_wd;
    logic             w_free_we;
    t_slot            w_free_wa;
    t_slot            w_free_wd;
    logic             w_next_we;
    t_slot            w_next_wa;
    t_link            w_next_wd;
    logic             w_slot_re;
    t_slot            w_slot_ra;

    // Derive bucket from the negated key, pop index and compare
    assign w_neg_key  = '0 - i_key;
    assign w_bkt_in   = w_neg_key[BKT_W-1:0];
    assign w_pop      = r_free_cnt - LINK_W'(1);
    assign w_hit      = (r_key_rd == r_key);
    assign w_rm_hit   = i_ctl.step && (r_cmd == CMD_REMOVE) && w_hit;
    assign w_push_ok  = r_free_cnt < NIL_LINK;
    assign w_clr_bkt  = {1'b0, r_clr_cnt} < (CLR_W + 1)'(BUCKETS);
    assign w_clr_slot = {1'b0, r_clr_cnt} < (CLR_W + 1)'(ENTRIES);

    // Select write ports
    always_comb begin
        w_head_we = 1'b0;
        w_head_wa = r_bkt;
        w_head_wd = r_next_rd;
        w_free_we = 1'b0;
        w_free_wa = r_free_cnt[SLOT_W-1:0];
        w_free_wd = r_cur[SLOT_W-1:0];
        w_next_we = 1'b0;
        w_next_wa = r_prev[SLOT_W-1:0];
        w_next_wd = r_next_rd;
        if (i_ctl.clr_step) begin
            w_head_we = w_clr_bkt;
            w_head_wa = r_clr_cnt[BKT_W-1:0];
            w_head_wd = NIL_LINK;
            w_free_we = w_clr_slot;
            w_free_wa = r_clr_cnt[SLOT_W-1:0];
            w_free_wd = r_clr_cnt[SLOT_W-1:0];
        end else if (i_ctl.ins_commit) begin
            w_head_we = 1'b1;
            w_head_wd = LINK_W'(r_free_rd);
            w_next_we = 1'b1;
            w_next_wa = r_free_rd;
            w_next_wd = r_head_rd;
        end else if (w_rm_hit) begin
            // Unlink from predecessor or from the bucket head, then free the slot
            w_head_we = !link_valid(r_prev);
            w_next_we = link_valid(r_prev);
            w_free_we = w_push_ok;
        end
    end

    // Select the slot read address: chain head or next link
    assign w_slot_re = (i_ctl.head && link_valid(r_head_rd))
                    || (i_ctl.step && link_valid(r_next_rd));
    assign w_slot_ra = i_ctl.head ? r_head_rd[SLOT_W-1:0] : r_next_rd[SLOT_W-1:0];

    // Bucket head memory
    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            m_head[w_head_wa] <= w_head_wd;
        end
        if (i_ctl.accept) begin
            r_head_rd <= m_head[w_bkt_in];
        end
    end

    // Free stack memory
    always_ff @(posedge i_clk) begin
        if (w_free_we) begin
            m_free[w_free_wa] <= w_free_wd;
        end
        if (i_ctl.accept) begin
            r_free_rd <= m_free[w_pop[SLOT_W-1:0]];
        end
    end

    // Slot key and value memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_commit) begin
            m_key[r_free_rd] <= r_key;
            m_val[r_free_rd] <= r_val;
        end
        if (w_slot_re) begin
            r_key_rd <= m_key[w_slot_ra];
            r_val_rd <= m_val[w_slot_ra];
        end
    end

    // Slot link memory
    always_ff @(posedge i_clk) begin
        if (w_next_we) begin
            m_next[w_next_wa] <= w_next_wd;
        end
        if (w_slot_re) begin
            r_next_rd <= m_next[w_slot_ra];
        end
    end

    // Capture the request, track the walk and build the result
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd  <= i_cmd;
            r_key  <= i_key;
            r_val  <= i_val;
            r_bkt  <= w_bkt_in;
            r_res  <= '0;
            r_stat <= ST_OK;
        end
        if (i_ctl.head) begin
            r_cur  <= r_head_rd;
            r_prev <= NIL_LINK;
        end
        if (i_ctl.step) begin
            r_cur <= r_next_rd;
            if (!w_rm_hit) begin
                r_prev <= r_cur;
            end
        end
        if (i_ctl.set_res) begin
            case (i_ctl.res_sel)
                RES_NOT_FOUND: begin
                    r_res  <= '0;
                    r_stat <= ST_NOT_FOUND;
                end
                RES_POOL_FULL: begin
                    r_res  <= '0;
                    r_stat <= ST_POOL_FULL;
                end
                RES_FOUND: begin
                    r_res  <= r_val_rd;
                    r_stat <= ST_OK;
                end
                default: begin
                    r_res  <= '0;
                    r_stat <= ST_OK;
                end
            endcase
        end
        if (i_ctl.load_out) begin
            r_out_value  <= r_res;
            r_out_status <= r_stat;
        end
    end

    // Advance the clear sweep and the free count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_free_cnt <= NIL_LINK;
        end else begin
            if (i_ctl.clr_step) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
            if (i_ctl.ins_commit) begin
                r_free_cnt <= w_pop;
            end else if (w_rm_hit && w_push_ok) begin
                r_free_cnt <= r_free_cnt + LINK_W'(1);
            end
        end
    end

    // Hold the response until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.clr_done   = (r_clr_cnt == CLR_W'(CLR_N - 1));
    assign o_stat.pool_empty = (r_free_cnt == '0);
    assign o_stat.head_nil   = !link_valid(r_head_rd);
    assign o_stat.hit        = w_hit;
    assign o_stat.next_nil   = !link_valid(r_next_rd);
    assign o_stat.out_free   = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid  = r_out_valid;
    assign o_rsp_value  = r_out_value;
    assign o_rsp_status = r_out_status;

endmodule

>>> rtl/chained_hash_key_value_table_unit.sv
// Requests are taken one at a time: an insert goes from idle to the insert state, a no-op
// straight to done; find and remove read the bucket head, then walk the chain, reading one
// slot a cycle from the slot memory. Ready returns the cycle after the previous response
// loads; a response waits in an output register while the next request is taken.
// Reset (synchronous, active low) starts a clearing pass that empties the bucket heads and
// refills the free stack; ready stays low until it ends.
`timescale 1ns / 1ps

module chained_hash_key_value_table_unit import chkvt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chkvt_req_if.sink   i_req,
    chkvt_rsp_if.source o_rsp
);

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic             w_ready;
    logic [VAL_W-1:0] w_value;
    logic [1:0]       w_status;

    assign i_req.ready = w_ready;

    // Sequence each request
    chkvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_cmd   (t_cmd'(i_req.cmd)),
        .o_req_ready (w_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Hold table storage and the response register
    chkvt_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (t_cmd'(i_req.cmd)),
        .i_key        (KEY_W'(unsigned'(i_req.lookup_key))),
        .i_val        (VAL_W'(unsigned'(i_req.entry_value))),
        .i_ctl        (w_cmd),
        .o_stat       (w_stat),
        .o_rsp_valid  (o_rsp.valid),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_value  (w_value),
        .o_rsp_status (w_status)
    );

    assign o_rsp.result_value = $signed(w_value);
    assign o_rsp.status       = w_status;

endmodule

>>> tb/sv/chkvt_table_checker.sv
// Checker: watches both channels, predicts every response from a table model and compares.
`timescale 1ns / 1ps

module chkvt_table_checker import chkvt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    chkvt_req_if  i_req,
    chkvt_rsp_if  i_rsp,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct {
        logic signed [VAL_W-1:0] value;
        t_status                 status;
    } t_reply;

    // Shadow copy of the table: chain heads, slot contents, links and free slots
    t_link            head_of   [BUCKETS];
    logic [KEY_W-1:0] key_of    [ENTRIES];
    logic [VAL_W-1:0] value_of  [ENTRIES];
    t_link            link_of   [ENTRIES];
    t_slot            free_slots[ENTRIES];
    int unsigned      free_left;

    t_reply replies_due[$];
    int     fail_count = 0;

    // Empty every chain and refill the free stack in slot order
    task automatic clear_table();
        for (int b = 0; b < BUCKETS; b++) head_of[t_bkt'(b)] = NIL_LINK;
        for (int s = 0; s < ENTRIES; s++) begin
            key_of[t_slot'(s)]     = '0;
            value_of[t_slot'(s)]   = '0;
            link_of[t_slot'(s)]    = NIL_LINK;
            free_slots[t_slot'(s)] = t_slot'(s);
        end
        free_left = ENTRIES;
        replies_due.delete();
    endtask

    // Apply one request to the shadow table and return the response it must produce
    function automatic t_reply table_apply(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] val);
        t_reply           r;
        logic [KEY_W-1:0] neg;
        t_bkt             b;
        t_link            cur;
        t_link            prev;
        t_link            nxt;
        int               guard;
        neg      = 32'd0 - key;
        b        = neg[BKT_W-1:0];
        r.value  = '0;
        r.status = ST_OK;
        guard    = 0;
        case (t_cmd'(cmd))
            CMD_INSERT: begin
                if (free_left == 0) begin
                    r.status = ST_POOL_FULL;
                end else begin
                    free_left                  = free_left - 1;
                    cur                        = {1'b0, free_slots[t_slot'(free_left)]};
                    key_of[cur[SLOT_W-1:0]]    = key;
                    value_of[cur[SLOT_W-1:0]]  = val;
                    link_of[cur[SLOT_W-1:0]]   = head_of[b];
                    head_of[b]                 = cur;
                end
            end
            CMD_REMOVE: begin
                // Unlink every match; read the link before the slot goes back to the pool
                prev = NIL_LINK;
                cur  = head_of[b];
                while (cur < NIL_LINK && guard < ENTRIES) begin
                    guard++;
                    nxt = link_of[cur[SLOT_W-1:0]];
                    if (key_of[cur[SLOT_W-1:0]] == key) begin
                        if (prev < NIL_LINK) link_of[prev[SLOT_W-1:0]] = nxt;
                        else head_of[b] = nxt;
                        link_of[cur[SLOT_W-1:0]] = NIL_LINK;
                        if (free_left < ENTRIES) begin
                            free_slots[t_slot'(free_left)] = cur[SLOT_W-1:0];
                            free_left = free_left + 1;
                        end
                    end else begin
                        prev = cur;
                    end
                    cur = nxt;
                end
            end
            CMD_FIND: begin
                // First match from the head is the newest entry
                r.status = ST_NOT_FOUND;
                cur      = head_of[b];
                while (cur < NIL_LINK && guard < ENTRIES) begin
                    guard++;
                    if (key_of[cur[SLOT_W-1:0]] == key) begin
                        r.value  = value_of[cur[SLOT_W-1:0]];
                        r.status = ST_OK;
                        break;
                    end
                    cur = link_of[cur[SLOT_W-1:0]];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("chk: %0t: %s", $realtime, what);
    endtask

    // Check responses first: one taken at the same edge as a request belongs to an older one
    always @(posedge i_clk) begin : watch
        t_reply due;
        if (!i_rst_n) begin
            clear_table();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (replies_due.size() == 0) begin
                    note_failure($sformatf("response with none due: value %0d status %0d",
                                           i_rsp.result_value, i_rsp.status));
                end else begin
                    due = replies_due.pop_front();
                    if (i_rsp.result_value !== due.value || i_rsp.status !== due.status)
                        note_failure($sformatf("expected value %0d status %s, got value %0d status %0d",
                                               due.value, due.status.name(),
                                               i_rsp.result_value, i_rsp.status));
                end
            end
            if (i_req.valid && i_req.ready)
                replies_due.push_back(table_apply(i_req.cmd, i_req.lookup_key, i_req.entry_value));
        end
        o_fail_count <= fail_count;
        o_pending    <= replies_due.size();
    end

endmodule

>>> tb/sv/tb_chained_hash_key_value_table_unit.sv
// Testbench top: clock, reset, request and response drivers, watchdog and verdict.
`timescale 1ns / 1ps

module tb_chained_hash_key_value_table_unit;
    import chkvt_pkg::*;

    localparam int IDLE_LIMIT = 8000;
    localparam int POOL_KEYS  = 64;
    localparam int POOL_W     = $clog2(POOL_KEYS);

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    chkvt_req_if req_ch();
    chkvt_rsp_if rsp_ch();

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   sent_count  = 0;
    bit   no_idle     = 1'b0;
    logic [31:0] key_pool[POOL_KEYS];

    always #4 i_clk = ~i_clk;

    chained_hash_key_value_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    chkvt_table_checker table_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // End the run when no request or response moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stall the response side for a random number of cycles per response
    initial begin : drain
        int stall;
        rsp_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            repeat (stall) begin
                rsp_ch.ready <= 1'b0;
                @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Drive one request after a random gap; enter and leave at a falling edge
    task automatic send_request(input t_cmd cmd, input logic [31:0] key, input logic [31:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.lookup_key  <= key;
        req_ch.entry_value <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        // Switch between idling and back-to-back stretches now and then
        sent_count++;
        if (sent_count % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
    endtask

    // Mostly keys from a small colliding set, some fully random, a few at the edges
    function automatic logic [31:0] pick_key();
        logic [31:0] edge_keys[5];
        edge_keys = '{32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF};
        case ($urandom_range(0, 9))
            7, 8:    return $urandom;
            9:       return edge_keys[3'($urandom_range(0, 4))];
            default: return key_pool[POOL_W'($urandom_range(0, POOL_KEYS - 1))];
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_mixed();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)       send_request(CMD_INSERT, pick_key(), pick_value());
        else if (pick < 12) send_request(CMD_REMOVE, pick_key(), $urandom);
        else if (pick < 19) send_request(CMD_FIND, pick_key(), $urandom);
        else                send_request(CMD_NOP, $urandom, $urandom);
    endtask

    initial begin : stimulus
        logic [31:0] neg;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_NOP;
        req_ch.lookup_key  = '0;
        req_ch.entry_value = '0;

        // Build colliding keys: eight buckets, including both end buckets
        for (int k = 0; k < POOL_KEYS; k++) begin
            neg = {1'b0, 21'($urandom), 10'((k % 8) * 146 + ((k % 8 == 7) ? 1 : 0))};
            if (neg == 0) neg = 32'd1024;
            key_pool[POOL_W'(k)] = 32'd0 - neg;
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty find, collisions, duplicates, edge keys, absent remove, no-op
        send_request(CMD_FIND,   32'hFFFF_FFFF, 32'h0);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(CMD_INSERT, 32'd1023,      32'h8000_0000);
        send_request(CMD_FIND,   32'hFFFF_FFFF, 32'h0);
        send_request(CMD_FIND,   32'd1023,      32'h0);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(CMD_FIND,   32'hFFFF_FFFF, 32'h0);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_FIND,   32'hFFFF_FFFF, 32'h0);
        send_request(CMD_FIND,   32'd1023,      32'h0);
        send_request(CMD_REMOVE, 32'hFFFF_FFFB, 32'h0);
        send_request(CMD_INSERT, 32'h8000_0001, 32'h5555_AAAA);
        send_request(CMD_INSERT, 32'h8000_0000, 32'hAAAA_5555);
        send_request(CMD_INSERT, 32'h0000_0000, 32'h0000_0001);
        send_request(CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_FIND,   32'h8000_0000, 32'h0);
        send_request(CMD_FIND,   32'h0000_0000, 32'h0);
        send_request(CMD_FIND,   32'h7FFF_FFFF, 32'h0);
        send_request(CMD_FIND,   32'h8000_0001, 32'h0);
        send_request(CMD_NOP,    32'h1234_5678, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, 32'h0000_0000, 32'h0);
        send_request(CMD_FIND,   32'h8000_0000, 32'h0);
        send_request(CMD_REMOVE, 32'd1023,      32'h0);
        send_request(CMD_FIND,   32'h7FFF_FFFF, 32'h0);

        // Random mix over the colliding keys
        repeat (676) send_mixed();

        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
